// File: hw/rtl/uer_pkg.sv
// Shared types and codes for the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

  // Item codes on the capture channel
  localparam logic MODE_ARM  = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  typedef logic [15:0] stamp_t;
  typedef logic [20:0] dist_t;
  typedef logic [10:0] period_t;

  // Stage handoff from the capture unit to the range unit
  typedef struct packed {
    logic   valid;
    stamp_t width;
  } meas_t;

endpackage
`default_nettype wire

// File: hw/rtl/uer_if.sv
// Channel interfaces for edge captures and range results.
`default_nettype none
interface uer_cap_if;
  logic          valid;
  logic          ready;
  logic          mode;
  uer_pkg::stamp_t capture_time;

  modport source (output valid, mode, capture_time, input ready);
  modport sink   (input valid, mode, capture_time, output ready);
endinterface

interface uer_res_if;
  logic             valid;
  logic             ready;
  uer_pkg::dist_t   distance_milli_cm;
  uer_pkg::period_t blink_period;
  logic             in_range;

  modport source (output valid, distance_milli_cm, blink_period, in_range, input ready);
  modport sink   (input valid, distance_milli_cm, blink_period, in_range, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/uer_capture.sv
// Edge capture state and pulse width measurement.
`default_nettype none
module uer_capture (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cap_valid,
  output logic                cap_ready,
  input  wire logic           cap_mode,
  input  wire uer_pkg::stamp_t cap_time,
  input  wire logic           meas_ready,
  output uer_pkg::meas_t      meas
);
  import uer_pkg::*;

  stamp_t start_stamp;
  logic   awaiting_fall;
  logic   capture_on;
  stamp_t pulse_width;
  logic   meas_valid;

  logic   accept;
  logic   is_edge;
  logic   fall;
  stamp_t width_next;

  // Take a new item whenever the handoff slot is free or draining
  assign cap_ready = !meas_valid || meas_ready;
  assign accept    = cap_valid && cap_ready;
  assign is_edge   = (cap_mode == MODE_EDGE) && capture_on;
  assign fall      = accept && is_edge && awaiting_fall;

  // Width with counter wrap; equal stamps keep the previous width
  always_comb begin
    if (cap_time > start_stamp) begin
      width_next = cap_time - start_stamp;
    end else if (start_stamp > cap_time) begin
      width_next = cap_time - start_stamp - 16'd1;
    end else begin
      width_next = pulse_width;
    end
  end

  // Hold capture state; advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      start_stamp   <= '0;
      awaiting_fall <= 1'b0;
      capture_on    <= 1'b1;
      pulse_width   <= '0;
      meas_valid    <= 1'b0;
    end else begin
      if (cap_ready) begin
        meas_valid <= fall;
      end
      if (accept) begin
        if (cap_mode == MODE_ARM) begin
          capture_on <= 1'b1;
        end else if (capture_on) begin
          if (!awaiting_fall) begin
            start_stamp   <= cap_time;
            awaiting_fall <= 1'b1;
          end else begin
            pulse_width   <= width_next;
            awaiting_fall <= 1'b0;
            capture_on    <= 1'b0;
          end
        end
      end
    end
  end

  // Width stays put while the slot is stalled, since no item is taken then
  assign meas.valid = meas_valid;
  assign meas.width = pulse_width;
endmodule
`default_nettype wire

// File: hw/rtl/uer_range.sv
// Distance scaling, band lookup and result register.
`default_nettype none
module uer_range (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire uer_pkg::meas_t   meas,
  output logic                  meas_ready,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output uer_pkg::dist_t        res_distance,
  output uer_pkg::period_t      res_period,
  output logic                  res_in_range
);
  import uer_pkg::*;

  localparam dist_t ALARM_LIMIT = 21'd25000;

  dist_t   dist_next;
  period_t period_next;
  logic    in_range_next;

  // Width times 17 as shift and add
  assign dist_next     = {1'b0, meas.width, 4'b0000} + {5'b00000, meas.width};
  assign in_range_next = (dist_next <= ALARM_LIMIT);

  // Pick blink reload by distance band
  always_comb begin
    if (dist_next > ALARM_LIMIT)      period_next = 11'd2000;
    else if (dist_next < 21'd2000)    period_next = 11'd99;
    else if (dist_next < 21'd4000)    period_next = 11'd110;
    else if (dist_next < 21'd6000)    period_next = 11'd124;
    else if (dist_next < 21'd8000)    period_next = 11'd141;
    else if (dist_next <= 21'd10000)  period_next = 11'd166;
    else if (dist_next <= 21'd12000)  period_next = 11'd199;
    else if (dist_next <= 21'd14000)  period_next = 11'd249;
    else if (dist_next <= 21'd16000)  period_next = 11'd332;
    else if (dist_next <= 21'd18000)  period_next = 11'd499;
    else                              period_next = 11'd999;
  end

  assign meas_ready = !res_valid || res_ready;

  // Hold the result until transfer; load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (meas_ready) begin
      res_valid <= meas.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_ready && meas.valid) begin
      res_distance <= dist_next;
      res_period   <= period_next;
      res_in_range <= in_range_next;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level.
//
// Channels: capture (sink) takes arm items (mode 0) and echo edge
// captures (mode 1) stamped by a free-running 16-bit microsecond counter.
// result (source) gives distance in thousandths of a cm, the alarm blink
// reload period and the in-range alarm flag, one per falling-edge capture.
// Arm items, ignored captures and rising-edge captures give no result.
// Path: the capture register loads on the falling-edge transfer, and the
// result register loads from it once the result stage is free; the result
// stays valid from then until it transfers out.
// Throughput: one item per cycle unless stalled; the ready of capture
// follows the handoff slot between the two registers, not the block state.
// Reset: capture enabled, no rising edge held, width and stamp zero,
// both stages empty.
// Stall: while result is held, one more result waits in the handoff slot;
// only then does capture drop ready. Arm and rising-edge items still flow
// whenever that slot is free.
`default_nettype none
module ultrasonic_echo_ranger (
  input  wire logic clk,
  input  wire logic rst,
  uer_cap_if.sink   capture,
  uer_res_if.source result
);
  import uer_pkg::*;

  meas_t meas;
  logic  meas_ready;

  uer_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .cap_valid  (capture.valid),
    .cap_ready  (capture.ready),
    .cap_mode   (capture.mode),
    .cap_time   (capture.capture_time),
    .meas_ready (meas_ready),
    .meas       (meas)
  );

  uer_range u_range (
    .clk          (clk),
    .rst          (rst),
    .meas         (meas),
    .meas_ready   (meas_ready),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_distance (result.distance_milli_cm),
    .res_period   (result.blink_period),
    .res_in_range (result.in_range)
  );
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the ultrasonic echo ranger: edge timing, bands and alarm.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import uer_pkg::*;

  localparam int RESET_CYCLES    = 8;
  localparam int TAIL_CYCLES     = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MCM_PER_TICK    = 17;
  localparam int ALARM_LIMIT_MCM = 25000;

  typedef struct packed {
    dist_t   distance_milli_cm;
    period_t blink_period;
    logic    in_range;
  } range_t;

  typedef struct packed {
    logic   mode;
    stamp_t stamp;
    bit     typed;
    range_t want;
  } probe_row_t;

  logic clk;
  logic rst;

  uer_cap_if cap_ch ();
  uer_res_if res_ch ();

  ultrasonic_echo_ranger u_dut (
    .clk     (clk),
    .rst     (rst),
    .capture (cap_ch),
    .result  (res_ch)
  );

  // Predictor state, mirrors the block after reset
  stamp_t rise_stamp;
  bit     rise_held;
  bit     edges_enabled;
  stamp_t last_width;

  range_t     range_expected[$];
  range_t     oldest_range;
  probe_row_t probe_rows[$];
  int         fail_count;
  int         accepted_useful;
  int         quiet_cycles;
  int         send_gap_pct;
  int         take_gap_pct;
  bit         stall_req;
  bit         stall_ack;

  always #2 clk = ~clk;

  // Reload period of the alarm blink timer for a distance in milli-cm
  function automatic period_t blink_for_distance(input dist_t d);
    if (d > ALARM_LIMIT_MCM) return 11'd2000;
    if (d < 2000)  return 11'd99;
    if (d < 4000)  return 11'd110;
    if (d < 6000)  return 11'd124;
    if (d < 8000)  return 11'd141;
    if (d <= 10000) return 11'd166;
    if (d <= 12000) return 11'd199;
    if (d <= 14000) return 11'd249;
    if (d <= 16000) return 11'd332;
    if (d <= 18000) return 11'd499;
    return 11'd999;
  endfunction

  // Advance the echo timing state by one accepted item
  task automatic range_step(input logic m, input stamp_t s, output range_t r,
                            output bit produced, output bit used);
    dist_t d;
    produced = 1'b0;
    used     = 1'b1;
    r        = '0;
    if (m == MODE_ARM) begin
      edges_enabled = 1'b1;
    end else if (!edges_enabled) begin
      used = 1'b0;
    end else if (!rise_held) begin
      rise_stamp = s;
      rise_held  = 1'b1;
    end else begin
      // wrap subtracts one extra tick, equal stamps keep the old width
      if (s > rise_stamp) last_width = s - rise_stamp;
      else if (rise_stamp > s) last_width = 16'hFFFF - rise_stamp + s;
      rise_held     = 1'b0;
      edges_enabled = 1'b0;
      d = dist_t'(last_width) * dist_t'(MCM_PER_TICK);
      r.distance_milli_cm = d;
      r.blink_period      = blink_for_distance(d);
      r.in_range          = (d <= ALARM_LIMIT_MCM);
      produced = 1'b1;
    end
  endtask

  // Offer one item, idle first at the current gap rate, return on the transfer
  task automatic send_item(input logic m, input stamp_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      cap_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cap_ch.valid        <= 1'b1;
    cap_ch.mode         <= m;
    cap_ch.capture_time <= s;
    do @(posedge clk); while (!cap_ch.ready);
  endtask

  task automatic issue(input logic m, input stamp_t s, input bit typed, input range_t want);
    range_t guess;
    bit     produced;
    bit     used;
    send_item(m, s);
    range_step(m, s, guess, produced, used);
    if (used) accepted_useful++;
    if (produced) range_expected.push_back(typed ? want : guess);
  endtask

  task automatic add_row(input logic m, input stamp_t s, input bit typed,
                         input dist_t d, input period_t p, input logic a);
    probe_row_t row;
    row.mode  = m;
    row.stamp = s;
    row.typed = typed;
    row.want  = '{distance_milli_cm: d, blink_period: p, in_range: a};
    probe_rows.push_back(row);
  endtask

  // One arm, rise, fall sequence with random stamps and width, sometimes with a second arm before the fall
  task automatic measure_once();
    stamp_t rise_at;
    stamp_t width;
    rise_at = stamp_t'($urandom);
    case ($urandom_range(9))
      0:       width = '0;
      1, 2:    width = stamp_t'($urandom);
      default: width = stamp_t'($urandom_range(1600));
    endcase
    issue(MODE_ARM, stamp_t'($urandom), 1'b0, '0);
    issue(MODE_EDGE, rise_at, 1'b0, '0);
    if ($urandom_range(4) == 0) issue(MODE_ARM, stamp_t'($urandom), 1'b0, '0);
    issue(MODE_EDGE, rise_at + width, 1'b0, '0);
  endtask

  // Mostly clean measurements, the rest stray edges and arms
  task automatic random_phase(input int count);
    int goal;
    int pick;
    goal = accepted_useful + count;
    while (accepted_useful < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) measure_once();
      else if (pick < 85) issue(MODE_EDGE, stamp_t'($urandom), 1'b0, '0);
      else issue(MODE_ARM, stamp_t'($urandom), 1'b0, '0);
    end
  endtask

  // Hold the sender until every predicted result has come back
  task automatic await_all_results();
    cap_ch.valid <= 1'b0;
    do @(posedge clk); while (range_expected.size() != 0);
  endtask

  // Result sink: random ready, plus a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (stall_req != stall_ack) begin
        stall_ack = stall_req;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (range_expected.size() == 0) begin
        $error("result with no prediction pending: distance_milli_cm %0d",
               res_ch.distance_milli_cm);
        fail_count++;
      end else begin
        oldest_range = range_expected.pop_front();
        if (res_ch.distance_milli_cm !== oldest_range.distance_milli_cm) begin
          $error("distance_milli_cm: expected %0d, got %0d",
                 oldest_range.distance_milli_cm, res_ch.distance_milli_cm);
          fail_count++;
        end
        if (res_ch.blink_period !== oldest_range.blink_period) begin
          $error("blink_period: expected %0d, got %0d",
                 oldest_range.blink_period, res_ch.blink_period);
          fail_count++;
        end
        if (res_ch.in_range !== oldest_range.in_range) begin
          $error("in_range: expected %0b, got %0b",
                 oldest_range.in_range, res_ch.in_range);
          fail_count++;
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (cap_ch.valid && cap_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cap_ch.valid        = 1'b0;
    cap_ch.mode         = MODE_ARM;
    cap_ch.capture_time = '0;
    rise_stamp          = '0;
    rise_held           = 1'b0;
    edges_enabled       = 1'b1;
    last_width          = '0;
    fail_count          = 0;
    accepted_useful     = 0;
    quiet_cycles        = 0;
    stall_req           = 1'b0;
    stall_ack           = 1'b0;
    send_gap_pct        = 22;
    take_gap_pct        = 62;

    // Directed rows: typed results where the answer is obvious
    add_row(MODE_EDGE, 16'h0000, 1'b0, 0, 0, 0);        // rise right after reset
    add_row(MODE_EDGE, 16'h0000, 1'b1, 0, 99, 1'b1);    // equal stamps keep width zero
    add_row(MODE_EDGE, 16'h1234, 1'b0, 0, 0, 0);        // capture off, dropped
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_ARM,  16'hFFFF, 1'b0, 0, 0, 0);        // arm twice
    add_row(MODE_EDGE, 16'hFFFF, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0000, 1'b1, 0, 99, 1'b1);    // wrap from top gives zero
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'hFFFF, 1'b1, 1114095, 2000, 1'b0); // widest pulse
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0005, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0005, 1'b1, 1114095, 2000, 1'b0); // equal stamps keep widest
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0064, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0622, 1'b0, 0, 0, 0);        // just inside alarm range
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'hFFF0, 1'b0, 0, 0, 0);
    add_row(MODE_ARM,  16'h5A5A, 1'b0, 0, 0, 0);        // arm while a rise is held
    add_row(MODE_EDGE, 16'h0010, 1'b0, 0, 0, 0);        // short pulse across wrap
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h8000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h85BF, 1'b0, 0, 0, 0);        // just past alarm range
    add_row(MODE_ARM,  16'h0000, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0001, 1'b0, 0, 0, 0);
    add_row(MODE_EDGE, 16'h0002, 1'b0, 0, 0, 0);        // one tick

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (probe_rows[i])
      issue(probe_rows[i].mode, probe_rows[i].stamp, probe_rows[i].typed, probe_rows[i].want);
    await_all_results();

    // Slow receiver, then slow sender, then full rate
    random_phase(230);
    await_all_results();
    send_gap_pct = 62;
    take_gap_pct = 22;
    random_phase(230);
    await_all_results();
    send_gap_pct = 0;
    take_gap_pct = 0;

    // Back up the result side while captures keep coming
    stall_req = ~stall_req;
    repeat (12) measure_once();
    await_all_results();
    random_phase(200);

    await_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/uer_pkg.sv
hw/rtl/uer_if.sv
hw/rtl/uer_capture.sv
hw/rtl/uer_range.sv
hw/rtl/ultrasonic_echo_ranger.sv
tb/sv/testbench.sv
